// ===== design/bpc_pkg.sv =====
// Shared types, constants and register indexes of the button press classifier.
package bpc_pkg;

  // Fixed field widths of the item channels.
  localparam int unsigned FieldW = 4;
  localparam int unsigned TimeW  = 32;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DOUBLE_GAP = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [7:0]  DEF_DEBOUNCE   = 8'd30;
  localparam logic [15:0] DEF_LONG_PRESS = 16'd500;
  localparam logic [15:0] DEF_DOUBLE_GAP = 16'd600;

  localparam int unsigned DEF_NUM_BUTTONS = 4;

  typedef struct packed {
    logic [7:0]  debounce_ms;
    logic [15:0] long_press_ms;
    logic [15:0] double_gap_ms;
  } bpc_cfg_t;

  typedef struct packed {
    logic short_ev;
    logic double_ev;
    logic long_ev;
  } bpc_lane_ev_t;

endpackage

// ===== design/bpc_if.sv =====
// Handshake interfaces for the tick items, result items and configuration writes.
interface bpc_in_if;
  import bpc_pkg::*;
  logic              valid;
  logic              ready;
  logic [FieldW-1:0] raw_pressed;
  logic [FieldW-1:0] cancellable;
  modport source (output valid, output raw_pressed, output cancellable, input ready);
  modport sink   (input valid, input raw_pressed, input cancellable, output ready);
endinterface

interface bpc_out_if;
  import bpc_pkg::*;
  logic              valid;
  logic              ready;
  logic [FieldW-1:0] short_event;
  logic [FieldW-1:0] double_event;
  logic [FieldW-1:0] long_event;
  modport source (output valid, output short_event, output double_event,
                  output long_event, input ready);
  modport sink   (input valid, input short_event, input double_event,
                  input long_event, output ready);
endinterface

interface bpc_cfg_if;
  import bpc_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/bpc_cfg_regs.sv =====
// Configuration register file of the button press classifier.
module bpc_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  bpc_cfg_if.sink          cfg_i,
  output bpc_pkg::bpc_cfg_t cfg_o
);
  import bpc_pkg::*;

  bpc_cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_DEBOUNCE:   cfg_d.debounce_ms   = cfg_i.data[7:0];
        REG_LONG_PRESS: cfg_d.long_press_ms = cfg_i.data;
        REG_DOUBLE_GAP: cfg_d.double_gap_ms = cfg_i.data;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms   <= DEF_DEBOUNCE;
      cfg_q.long_press_ms <= DEF_LONG_PRESS;
      cfg_q.double_gap_ms <= DEF_DOUBLE_GAP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/bpc_lane.sv =====
// One button lane: debounce, long press detection and short/double release classing.
module bpc_lane (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    advance_i,
  input  logic [bpc_pkg::TimeW-1:0] now_i,
  input  bpc_pkg::bpc_cfg_t       cfg_i,
  input  logic                    raw_i,
  input  logic                    ok_i,
  output bpc_pkg::bpc_lane_ev_t   ev_o
);
  import bpc_pkg::*;

  logic             raw_last_q, raw_last_d;
  logic [TimeW-1:0] edge_time_q, edge_time_d;
  logic             stable_q, stable_d;
  logic [TimeW-1:0] press_time_q, press_time_d;
  logic             long_done_q, long_done_d;
  logic [TimeW-1:0] short_time_q, short_time_d;

  logic [TimeW-1:0] hold;
  logic [TimeW-1:0] since_edge;
  logic             settled;
  logic             long_hit;
  logic             near;

  // A zero long press time falls back to the default.
  assign hold = (cfg_i.long_press_ms == '0) ? TimeW'(DEF_LONG_PRESS)
                                            : TimeW'(cfg_i.long_press_ms);

  assign raw_last_d  = raw_i;
  assign edge_time_d = (raw_i != raw_last_q) ? now_i : edge_time_q;
  assign since_edge  = now_i - edge_time_d;
  assign settled     = since_edge >= TimeW'(cfg_i.debounce_ms);
  assign long_hit    = (now_i - press_time_q) >= hold;
  assign near        = (now_i - short_time_q) <= TimeW'(cfg_i.double_gap_ms);

  always_comb begin
    stable_d     = stable_q;
    press_time_d = press_time_q;
    long_done_d  = long_done_q;
    short_time_d = short_time_q;
    ev_o         = '0;
    if (settled) begin
      priority if (raw_i && !stable_q) begin
        stable_d     = 1'b1;
        press_time_d = now_i;
        long_done_d  = 1'b0;
      end else if (raw_i && stable_q && !long_done_q && long_hit) begin
        long_done_d  = 1'b1;
        ev_o.long_ev = 1'b1;
      end else if (!raw_i && stable_q) begin
        stable_d = 1'b0;
        if (!long_done_q) begin
          // An accepted double forgets the previous release time.
          if (near && ok_i) begin
            ev_o.double_ev = 1'b1;
            short_time_d   = '0;
          end else begin
            ev_o.short_ev  = 1'b1;
            short_time_d   = now_i;
          end
        end
      end else begin
        // The debounced level holds and no long press is due, so nothing changes.
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_last_q   <= 1'b0;
      edge_time_q  <= '0;
      stable_q     <= 1'b0;
      press_time_q <= '0;
      long_done_q  <= 1'b0;
      short_time_q <= '0;
    end else if (advance_i) begin
      raw_last_q   <= raw_last_d;
      edge_time_q  <= edge_time_d;
      stable_q     <= stable_d;
      press_time_q <= press_time_d;
      long_done_q  <= long_done_d;
      short_time_q <= short_time_d;
    end
  end

endmodule

// ===== design/bpc_merge.sv =====
// Gathers the lane events into the result fields and holds them in the output register.
module bpc_merge #(
  parameter int unsigned NUM_BUTTONS = bpc_pkg::DEF_NUM_BUTTONS
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  bpc_pkg::bpc_lane_ev_t [NUM_BUTTONS-1:0]  lane_ev_i,
  bpc_out_if.source                                out_o
);
  import bpc_pkg::*;

  logic              valid_q;
  logic [FieldW-1:0] short_d, double_d, long_d;
  logic [FieldW-1:0] short_q, double_q, long_q;
  logic              load;

  // Buttons past the field width never show; missing buttons read zero.
  for (genvar i = 0; i < FieldW; i++) begin : g_field
    if (i < NUM_BUTTONS) begin : g_on
      assign short_d[i]  = lane_ev_i[i].short_ev;
      assign double_d[i] = lane_ev_i[i].double_ev;
      assign long_d[i]   = lane_ev_i[i].long_ev;
    end else begin : g_off
      assign short_d[i]  = 1'b0;
      assign double_d[i] = 1'b0;
      assign long_d[i]   = 1'b0;
    end
  end

  assign in_ready_o = !valid_q || out_o.ready;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      short_q  <= short_d;
      double_q <= double_d;
      long_q   <= long_d;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.short_event  = short_q;
  assign out_o.double_event = double_q;
  assign out_o.long_event   = long_q;

endmodule

// ===== design/button_press_classifier_unit.sv =====
// Top level of the button press classifier: config registers, button lanes and output stage.
//
//   channel  dir  carries
//   in_i     in   raw_pressed, cancellable (one millisecond tick per item)
//   out_o    out  short_event, double_event, long_event (one result per tick)
//   cfg_i    in   index, data (register writes, always ready)
//
// Each tick item is classified combinationally by NUM_BUTTONS lanes in parallel, so one
// item is accepted per cycle unless out_o stalls; its result is registered on the next cycle.
// The 32-bit tick counter and all lane state advance only on an accepted item.
// Input ready drops only while a result waits in the output register and out_o is stalled.
// Reset restores the default timings and clears the counter and all lane state at once.
module button_press_classifier_unit #(
  parameter int unsigned NUM_BUTTONS = bpc_pkg::DEF_NUM_BUTTONS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bpc_in_if.sink    in_i,
  bpc_out_if.source out_o,
  bpc_cfg_if.sink   cfg_i
);
  import bpc_pkg::*;

  bpc_cfg_t                           cfg;
  bpc_lane_ev_t [NUM_BUTTONS-1:0]     lane_ev;
  logic         [TimeW-1:0]           tick_q;
  logic                               accept;

  assign accept = in_i.valid && in_i.ready;

  bpc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
    end else if (accept) begin
      tick_q <= tick_q + TimeW'(1);
    end
  end

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    logic raw;
    logic ok;
    if (b < FieldW) begin : g_in
      assign raw = in_i.raw_pressed[b];
      assign ok  = in_i.cancellable[b];
    end else begin : g_none
      assign raw = 1'b0;
      assign ok  = 1'b0;
    end

    bpc_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (accept),
      .now_i     (tick_q),
      .cfg_i     (cfg),
      .raw_i     (raw),
      .ok_i      (ok),
      .ev_o      (lane_ev[b])
    );
  end

  bpc_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .lane_ev_i  (lane_ev),
    .out_o      (out_o)
  );

  // An accepted tick always leaves a result in the output register.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_o.valid)
    else $error("accepted tick produced no result");

  // The time base moves by exactly one per accepted tick.
  a_tick_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> tick_q == $past(tick_q) + TimeW'(1))
    else $error("tick counter did not step on accept");

  a_tick_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(tick_q))
    else $error("tick counter moved without an accepted tick");

  // A button reports at most one kind of event per tick.
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.short_event & out_o.double_event) == '0 &&
                     (out_o.short_event & out_o.long_event) == '0 &&
                     (out_o.double_event & out_o.long_event) == '0))
    else $error("button reported more than one event kind");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the button press classifier: directed rows, then scripted random presses.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bpc_pkg::*;

  localparam int unsigned NumButtons = DEF_NUM_BUTTONS;
  localparam int unsigned CycleLimit = 200000;
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [FieldW-1:0] short_ev;
    logic [FieldW-1:0] double_ev;
    logic [FieldW-1:0] long_ev;
  } press_events_t;

  typedef enum logic [1:0] {ROW_TICK, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    logic [FieldW-1:0]   raw;
    logic [FieldW-1:0]   canc;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    bit                  typed;
    press_events_t       ev;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bpc_in_if  tick_if ();
  bpc_out_if ev_if ();
  bpc_cfg_if cfg_if ();

  button_press_classifier_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (tick_if),
    .out_o  (ev_if),
    .cfg_i  (cfg_if)
  );

  always #4ns clk_i = ~clk_i;

  // Behavioral copy of the configuration and of the per-button state.
  logic [7:0]       cfg_debounce = DEF_DEBOUNCE;
  logic [15:0]      cfg_long     = DEF_LONG_PRESS;
  logic [15:0]      cfg_gap      = DEF_DOUBLE_GAP;
  logic [TimeW-1:0] tick_now     = '0;
  logic             raw_seen   [NumButtons] = '{default: 1'b0};
  logic [TimeW-1:0] edge_at    [NumButtons] = '{default: '0};
  logic             stable_lvl [NumButtons] = '{default: 1'b0};
  logic [TimeW-1:0] press_at   [NumButtons] = '{default: '0};
  logic             long_fired [NumButtons] = '{default: 1'b0};
  logic [TimeW-1:0] release_at [NumButtons] = '{default: '0};

  press_events_t pending_events [$];
  stim_row_t     stim_rows [$];

  // Random press script: wanted level per button and ticks left at that level.
  logic want_lvl  [NumButtons] = '{default: 1'b0};
  int   hold_left [NumButtons] = '{default: 0};

  bit          idle_on = 1'b1;
  int unsigned errors = 0;
  int unsigned ticks_sent = 0;
  int unsigned results_seen = 0;
  int unsigned settings_run = 0;
  int unsigned n_short = 0, n_double = 0, n_long = 0;

  function automatic press_events_t classify_tick(logic [FieldW-1:0] raw_bits,
                                                  logic [FieldW-1:0] ok_bits);
    press_events_t    ev;
    logic [TimeW-1:0] hold;
    logic             near;
    ev = '0;
    hold = (cfg_long == '0) ? TimeW'(DEF_LONG_PRESS) : TimeW'(cfg_long);
    for (int b = 0; b < NumButtons; b++) begin
      if (raw_bits[b] != raw_seen[b]) begin
        raw_seen[b] = raw_bits[b];
        edge_at[b] = tick_now;
      end
      if (tick_now - edge_at[b] >= TimeW'(cfg_debounce)) begin
        if (raw_bits[b] && !stable_lvl[b]) begin
          stable_lvl[b] = 1'b1;
          press_at[b] = tick_now;
          long_fired[b] = 1'b0;
        end else if (raw_bits[b] && !long_fired[b] && tick_now - press_at[b] >= hold) begin
          long_fired[b] = 1'b1;
          ev.long_ev[b] = 1'b1;
        end else if (!raw_bits[b] && stable_lvl[b]) begin
          stable_lvl[b] = 1'b0;
          if (!long_fired[b]) begin
            near = (tick_now - release_at[b]) <= TimeW'(cfg_gap);
            release_at[b] = tick_now;
            if (near && ok_bits[b]) begin
              ev.double_ev[b] = 1'b1;
              release_at[b] = '0;
            end else begin
              ev.short_ev[b] = 1'b1;
            end
          end
        end
      end
    end
    tick_now = tick_now + 1'b1;
    return ev;
  endfunction

  function automatic void check_field(string name, logic [FieldW-1:0] want,
                                      logic [FieldW-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  task automatic tick_row(logic [FieldW-1:0] raw, logic [FieldW-1:0] canc, bit typed,
                          logic [FieldW-1:0] s, logic [FieldW-1:0] d, logic [FieldW-1:0] l);
    stim_row_t row;
    row.kind = ROW_TICK;
    row.raw = raw;
    row.canc = canc;
    row.idx = REG_DEBOUNCE;
    row.data = '0;
    row.typed = typed;
    row.ev = {s, d, l};
    stim_rows.push_back(row);
  endtask

  task automatic cfg_row(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.raw = '0;
    row.canc = '0;
    row.idx = idx;
    row.data = data;
    row.typed = 1'b0;
    row.ev = '0;
    stim_rows.push_back(row);
  endtask

  // Called at a falling edge; returns at a falling edge once the register is written and valid is dropped.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_DEBOUNCE:   cfg_debounce = data[7:0];
      REG_LONG_PRESS: cfg_long = data;
      REG_DOUBLE_GAP: cfg_gap = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    tick_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_events.size() != 0) @(negedge clk_i);
  endtask

  // Called at a falling edge; returns at the falling edge after the item is accepted.
  task automatic send_tick(logic [FieldW-1:0] raw, logic [FieldW-1:0] canc, bit typed,
                           press_events_t typed_ev);
    press_events_t ev;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      tick_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    tick_if.valid       <= 1'b1;
    tick_if.raw_pressed <= raw;
    tick_if.cancellable <= canc;
    do @(posedge clk_i); while (!tick_if.ready);
    ev = classify_tick(raw, canc);
    pending_events.push_back(typed ? typed_ev : ev);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  // One register setting followed by scripted presses whose lengths straddle the
  // debounce, long press and double gap boundaries of that setting.
  task automatic run_phase(int unsigned db, int unsigned lp, int unsigned gap,
                           int unsigned n_items, bit pause_midway);
    logic [FieldW-1:0] raw, canc;
    int unsigned       hold, pick, bounce_max, press_max, gap_max;
    drain_results();
    write_reg(REG_DEBOUNCE, CfgDataW'(db));
    write_reg(REG_LONG_PRESS, CfgDataW'(lp));
    write_reg(REG_DOUBLE_GAP, CfgDataW'(gap));
    settings_run++;
    hold = (lp == 0) ? int'(DEF_LONG_PRESS) : lp;
    bounce_max = (db == 0) ? 1 : ((db < 8) ? db : 8);
    press_max = (hold < 60) ? hold : 60;
    gap_max = (2 * gap + 2 < 80) ? 2 * gap + 2 : 80;
    for (int b = 0; b < NumButtons; b++) hold_left[b] = 0;
    for (int i = 0; i < n_items; i++) begin
      for (int b = 0; b < NumButtons; b++) begin
        if (hold_left[b] == 0) begin
          want_lvl[b] = !want_lvl[b];
          pick = $urandom_range(0, 19);
          if (pick < 3)
            hold_left[b] = $urandom_range(1, bounce_max);
          else if (want_lvl[b] && pick >= 16 && hold <= 600)
            hold_left[b] = db + hold + $urandom_range(1, 4);
          else if (want_lvl[b])
            hold_left[b] = db + $urandom_range(1, press_max);
          else
            hold_left[b] = db + $urandom_range(1, gap_max);
        end
        raw[b] = want_lvl[b];
        hold_left[b]--;
      end
      // Occasional glitch tick that breaks the script.
      if ($urandom_range(0, 19) == 0) raw = FieldW'($urandom_range(0, 15));
      canc = FieldW'($urandom_range(0, 15) | $urandom_range(0, 15));
      send_tick(raw, canc, 1'b0, '0);
      if (pause_midway && i == n_items / 2) drain_results();
    end
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    ev_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (idle_on && stall_left > 0) begin
        ev_if.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        ev_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 8);
      end else begin
        ev_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    press_events_t want;
    if (rst_ni && ev_if.valid && ev_if.ready) begin
      if (pending_events.size() == 0) begin
        errors++;
        $display("%0t ns: result with no item pending, expected none, actual %h %h %h",
                 $time, ev_if.short_event, ev_if.double_event, ev_if.long_event);
      end else begin
        want = pending_events.pop_front();
        check_field("short_event", want.short_ev, ev_if.short_event);
        check_field("double_event", want.double_ev, ev_if.double_event);
        check_field("long_event", want.long_ev, ev_if.long_event);
        results_seen++;
        n_short += $countones(ev_if.short_event);
        n_double += $countones(ev_if.double_event);
        n_long += $countones(ev_if.long_event);
      end
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("timeout after %0d cycles", CycleLimit);
    $display("testbench failed");
    $finish;
  end

  initial begin
    rst_ni <= 1'b0;
    tick_if.valid <= 1'b0;
    tick_if.raw_pressed <= '0;
    tick_if.cancellable <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_DEBOUNCE;
    cfg_if.data <= '0;

    // Inside the default debounce window nothing can be trusted yet.
    tick_row(4'hF, 4'hF, 1, 4'h0, 4'h0, 4'h0);
    tick_row(4'h0, 4'h0, 1, 4'h0, 4'h0, 4'h0);
    tick_row(4'hA, 4'h5, 1, 4'h0, 4'h0, 4'h0);
    tick_row(4'h5, 4'hA, 1, 4'h0, 4'h0, 4'h0);
    // Upper data bits are dropped, so this selects a zero debounce.
    cfg_row(REG_DEBOUNCE, 16'hFF00);
    tick_row(4'hF, 4'hF, 1, 4'h0, 4'h0, 4'h0);
    // The first release after reset sits within the gap of time zero.
    tick_row(4'h0, 4'hF, 1, 4'h0, 4'hF, 4'h0);
    tick_row(4'hF, 4'h0, 1, 4'h0, 4'h0, 4'h0);
    tick_row(4'h0, 4'h0, 1, 4'hF, 4'h0, 4'h0);
    tick_row(4'hF, 4'hF, 0, 4'h0, 4'h0, 4'h0);
    tick_row(4'h0, 4'hF, 0, 4'h0, 4'h0, 4'h0);
    cfg_row(REG_LONG_PRESS, 16'd1);
    cfg_row(REG_DOUBLE_GAP, 16'd0);
    tick_row(4'h3, 4'h0, 0, 4'h0, 4'h0, 4'h0);
    tick_row(4'h3, 4'h0, 0, 4'h0, 4'h0, 4'h0);
    tick_row(4'h3, 4'h5, 0, 4'h0, 4'h0, 4'h0);
    tick_row(4'h0, 4'hF, 0, 4'h0, 4'h0, 4'h0);
    tick_row(4'hC, 4'hF, 0, 4'h0, 4'h0, 4'h0);
    tick_row(4'h0, 4'hF, 0, 4'h0, 4'h0, 4'h0);
    cfg_row(REG_UNUSED, 16'hFFFF);
    cfg_row(REG_DEBOUNCE, 16'd2);
    tick_row(4'h1, 4'hF, 0, 4'h0, 4'h0, 4'h0);
    tick_row(4'h0, 4'hF, 0, 4'h0, 4'h0, 4'h0);
    tick_row(4'h1, 4'hF, 0, 4'h0, 4'h0, 4'h0);
    tick_row(4'h1, 4'hF, 0, 4'h0, 4'h0, 4'h0);
    tick_row(4'h1, 4'hF, 0, 4'h0, 4'h0, 4'h0);
    tick_row(4'h1, 4'hF, 0, 4'h0, 4'h0, 4'h0);
    tick_row(4'h0, 4'hF, 0, 4'h0, 4'h0, 4'h0);
    tick_row(4'h0, 4'hF, 0, 4'h0, 4'h0, 4'h0);
    tick_row(4'h0, 4'hF, 0, 4'h0, 4'h0, 4'h0);

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(stim_rows[i].idx, stim_rows[i].data);
      end else begin
        send_tick(stim_rows[i].raw, stim_rows[i].canc, stim_rows[i].typed, stim_rows[i].ev);
      end
    end

    // A zero long press time falls back to the default hold, so no long event shows here.
    run_phase(0, 0, 0, 100, 1'b0);
    run_phase(2, 4, 10, 50, 1'b1);
    run_phase(1, 1, 1, 30, 1'b0);
    run_phase(5, 12, 30, 40, 1'b0);
    run_phase(1, 65535, 65535, 30, 1'b0);
    run_phase(40, 1, 3, 60, 1'b0);
    repeat (3) run_phase($urandom_range(0, 6), $urandom_range(1, 15), $urandom_range(0, 30),
                         20, 1'b0);
    drain_results();
    idle_on = 1'b0;
    run_phase($urandom_range(0, 6), $urandom_range(1, 15), $urandom_range(0, 30), 40, 1'b0);

    drain_results();
    repeat (4) @(posedge clk_i);
    $display("Sent %0d tick items over %0d register settings plus directed rows.",
             ticks_sent, settings_run);
    $display("Checked %0d results holding %0d short, %0d double and %0d long events.",
             results_seen, n_short, n_double, n_long);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/bpc_pkg.sv
design/bpc_if.sv
design/bpc_cfg_regs.sv
design/bpc_lane.sv
design/bpc_merge.sv
design/button_press_classifier_unit.sv
tb/testbench.sv
